// ===== rtl/core/hbm_pkg.sv =====
// Shared types and constants for the Hamming best-match ratio test block.
package hbm_pkg;

  localparam int WORD_W    = 64;
  localparam int DESC_W    = 4 * WORD_W;
  localparam int DIST_W    = 9;
  localparam int IDX_W     = 12;
  localparam int OCT_W     = 3;
  localparam int CFG_REG_W = 9;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Candidates whose index reaches this count are dropped.
  localparam int KEYPOINT_COUNT = 4096;
  localparam int KP_CMP_W       = 17;

  localparam logic [DIST_W-1:0]    NO_DIST       = 9'd256;
  localparam logic [CFG_REG_W-1:0] THRESHOLD_RST = 9'd50;
  localparam logic [CFG_REG_W-1:0] RATIO_RST     = 9'd230;

  localparam logic [WORD_W-1:0] POP_M1 = 64'h5555_5555_5555_5555;
  localparam logic [WORD_W-1:0] POP_M2 = 64'h3333_3333_3333_3333;
  localparam logic [WORD_W-1:0] POP_M4 = 64'h0F0F_0F0F_0F0F_0F0F;

  typedef enum logic [0:0] {
    REG_THRESHOLD = 1'b0,
    REG_RATIO     = 1'b1
  } hbm_reg_t;

  // Item after the distance stage.
  typedef struct packed {
    logic              is_query;
    logic              last;
    logic              use_cand;
    logic [DIST_W-1:0] ham_dist;
    logic [IDX_W-1:0]  cidx;
  } hbm_stage_t;

  // Snapshot of a finished run, waiting for the acceptance tests.
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] best;
    logic [DIST_W-1:0] second;
  } hbm_result_t;

endpackage

// ===== rtl/core/hbm_popcount.sv =====
// Hamming distance between two 256-bit descriptors: XOR, then an adder-tree popcount.
module hbm_popcount
  import hbm_pkg::*;
(
  input  logic [DESC_W-1:0] desc_a,
  input  logic [DESC_W-1:0] desc_b,
  output logic [DIST_W-1:0] distance
);

  logic [WORD_W-1:0] x  [4];
  logic [WORD_W-1:0] v1 [4];
  logic [WORD_W-1:0] v2 [4];
  logic [WORD_W-1:0] v4 [4];
  logic [3:0] byte_cnt [32];
  logic [4:0] sum16 [16];
  logic [5:0] sum8  [8];
  logic [6:0] sum4  [4];
  logic [7:0] sum2  [2];

  // Bit-sliced counting per 64-bit word leaves one count per byte.
  always_comb begin
    for (int w = 0; w < 4; w++) begin
      x[w]  = desc_a[w*WORD_W +: WORD_W] ^ desc_b[w*WORD_W +: WORD_W];
      v1[w] = x[w] - ((x[w] >> 1) & POP_M1);
      v2[w] = (v1[w] & POP_M2) + ((v1[w] >> 2) & POP_M2);
      v4[w] = (v2[w] + (v2[w] >> 4)) & POP_M4;
      for (int k = 0; k < 8; k++) begin
        byte_cnt[w*8+k] = v4[w][k*8 +: 4];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sum16[i] = 5'(byte_cnt[2*i]) + 5'(byte_cnt[2*i+1]);
    end
    for (int i = 0; i < 8; i++) begin
      sum8[i] = 6'(sum16[2*i]) + 6'(sum16[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      sum4[i] = 7'(sum8[2*i]) + 7'(sum8[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      sum2[i] = 8'(sum4[2*i]) + 8'(sum4[2*i+1]);
    end
  end

  assign distance = DIST_W'(sum2[0]) + DIST_W'(sum2[1]);

endmodule

// ===== rtl/core/hamming_best_match_ratio_test.sv =====
// Top level of the Hamming best-match ratio test block.
//
// Input channel (in_valid/in_ready): a query transaction (in_func = 0) loads the
// 256-bit query descriptor and starts a new run; each candidate transaction
// (in_func = 1) is compared against the loaded query, if its octave was 0. A transaction
// with in_last set closes the run and produces one result transaction on the
// output channel (out_valid/out_ready); other transactions produce none.
// Configuration goes through the APB port: distance threshold at address 0,
// ratio (scaled by 256) at address 4. pready is always high.
//
// Throughput is one transaction per cycle while in_ready is high. The pipeline has
// an input register, a distance stage (XOR and popcount tree), a run update stage and
// the output register, where the threshold and ratio tests are taken (one 9 by 9
// multiply). A closing transaction's result passes through each of them in turn.
// While a result waits, transactions that do not close a run keep flowing; a second
// closing transaction waits after the run update stage, a third after the distance
// stage, and in_ready falls only once the input register also holds a transaction.
// Reset empties the pipeline, clears the run and the query enable, and returns
// both configuration registers to their reset values.
module hamming_best_match_ratio_test
  import hbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_func,
  input  logic [WORD_W-1:0]     in_desc_word0,
  input  logic [WORD_W-1:0]     in_desc_word1,
  input  logic [WORD_W-1:0]     in_desc_word2,
  input  logic [WORD_W-1:0]     in_desc_word3,
  input  logic [OCT_W-1:0]      in_octave,
  input  logic [IDX_W-1:0]      in_candidate_index,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic                  out_accepted,
  output logic [IDX_W-1:0]      out_match_index,
  output logic [DIST_W-1:0]     out_best_distance,
  output logic [DIST_W-1:0]     out_second_distance
);

  // Configuration registers
  logic [CFG_REG_W-1:0] threshold_r;
  logic [CFG_REG_W-1:0] ratio_r;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      ratio_r     <= RATIO_RST;
    end else if (cfg_write) begin
      unique case (hbm_reg_t'(paddr[2]))
        REG_THRESHOLD: threshold_r <= pwdata[CFG_REG_W-1:0];
        REG_RATIO:     ratio_r     <= pwdata[CFG_REG_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (hbm_reg_t'(paddr[2]))
      REG_THRESHOLD: prdata = APB_DATA_W'(threshold_r);
      REG_RATIO:     prdata = APB_DATA_W'(ratio_r);
      default:       prdata = '0;
    endcase
  end

  // Pipeline flow control
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic out_free, s3_free, s2_free, s2_move, s3_move, s1_move, in_take;
  hbm_stage_t s2_r;

  assign out_free = !out_v_r || out_ready;
  assign s3_move  = s3_v_r && out_free;
  assign s3_free  = !s3_v_r || out_free;
  // Only a closing transaction needs room in the result stage.
  assign s2_move  = s2_v_r && (!s2_r.last || s3_free);
  assign s2_free  = !s2_v_r || s2_move;
  assign s1_move  = s1_v_r && s2_free;
  assign in_ready = !s1_v_r || s2_free;
  assign in_take  = in_valid && in_ready;

  // Input register
  logic              s1_func_r, s1_last_r;
  logic [DESC_W-1:0] s1_desc_r;
  logic [OCT_W-1:0]  s1_oct_r;
  logic [IDX_W-1:0]  s1_cidx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r <= in_func;
      s1_last_r <= in_last;
      s1_desc_r <= {in_desc_word3, in_desc_word2, in_desc_word1, in_desc_word0};
      s1_oct_r  <= in_octave;
      s1_cidx_r <= in_candidate_index;
    end
  end

  // Distance stage: the query is loaded as its transaction leaves the input register,
  // so a candidate right behind it already sees the new descriptor.
  logic [DESC_W-1:0] query_r;
  logic              query_en_r;
  logic [DIST_W-1:0] ham_dist;
  logic              in_range;
  hbm_stage_t        s2_nxt;

  hbm_popcount u_popcount (
    .desc_a   (query_r),
    .desc_b   (s1_desc_r),
    .distance (ham_dist)
  );

  assign in_range = KP_CMP_W'(s1_cidx_r) < KP_CMP_W'(KEYPOINT_COUNT);

  always_comb begin
    s2_nxt.is_query = !s1_func_r;
    s2_nxt.last     = s1_last_r;
    s2_nxt.use_cand = s1_func_r && query_en_r && in_range;
    s2_nxt.ham_dist = ham_dist;
    s2_nxt.cidx     = s1_cidx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_en_r <= 1'b0;
    end else if (s1_move && !s1_func_r) begin
      query_en_r <= (s1_oct_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && !s1_func_r) begin
      query_r <= s1_desc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_r <= s2_nxt;
    end
  end

  // Run update stage
  logic [DIST_W-1:0] best_r, second_r, best_nxt, second_nxt;
  logic [IDX_W-1:0]  bidx_r, bidx_nxt;
  logic              have_r, have_nxt;
  hbm_result_t       s3_r;

  always_comb begin
    best_nxt   = best_r;
    second_nxt = second_r;
    bidx_nxt   = bidx_r;
    have_nxt   = have_r;
    if (s2_r.is_query) begin
      best_nxt   = NO_DIST;
      second_nxt = NO_DIST;
      bidx_nxt   = '0;
      have_nxt   = 1'b0;
    end else if (s2_r.use_cand) begin
      if (s2_r.ham_dist < best_r) begin
        second_nxt = best_r;
        best_nxt   = s2_r.ham_dist;
        bidx_nxt   = s2_r.cidx;
        have_nxt   = 1'b1;
      end else if (s2_r.ham_dist < second_r) begin
        second_nxt = s2_r.ham_dist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r   <= NO_DIST;
      second_r <= NO_DIST;
      bidx_r   <= '0;
      have_r   <= 1'b0;
    end else if (s2_move) begin
      if (s2_r.last) begin
        // The run is reported, so the next one starts clean against the same query.
        best_r   <= NO_DIST;
        second_r <= NO_DIST;
        bidx_r   <= '0;
        have_r   <= 1'b0;
      end else begin
        best_r   <= best_nxt;
        second_r <= second_nxt;
        bidx_r   <= bidx_nxt;
        have_r   <= have_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_free) begin
      s3_v_r <= s2_move && s2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move && s2_r.last) begin
      s3_r.found  <= have_nxt;
      s3_r.index  <= bidx_nxt;
      s3_r.best   <= best_nxt;
      s3_r.second <= second_nxt;
    end
  end

  // Output register with the threshold and ratio tests
  logic                  thr_ok, ratio_ok;
  logic [2*DIST_W-1:0]   best_scaled, second_scaled;

  assign best_scaled   = (2*DIST_W)'({s3_r.best, 8'h00});
  assign second_scaled = (2*DIST_W)'(s3_r.second) * (2*DIST_W)'(ratio_r);
  assign thr_ok        = s3_r.best <= threshold_r;
  assign ratio_ok      = best_scaled < second_scaled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_move) begin
      out_found           <= s3_r.found;
      out_accepted        <= s3_r.found && thr_ok && ratio_ok;
      out_match_index     <= s3_r.index;
      out_best_distance   <= s3_r.best;
      out_second_distance <= s3_r.second;
    end
  end

  assign out_valid = out_v_r;

endmodule

// ===== rtl/core/hbm_checker.sv =====
// Port-level checks for the Hamming best-match ratio test block, bound to the top level.
module hbm_checker
  import hbm_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_found,
  input logic              out_accepted,
  input logic [IDX_W-1:0]  out_match_index,
  input logic [DIST_W-1:0] out_best_distance,
  input logic [DIST_W-1:0] out_second_distance
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_distance)
      && $stable(out_second_distance) && $stable(out_match_index))
    else $error("result changed while stalled");

  // Without a match the run must report its initial distances and index.
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_index == '0 && !out_accepted
      && out_best_distance == NO_DIST && out_second_distance == NO_DIST)
    else $error("empty run reported non-initial values");

  // Best and second are kept in order.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_best_distance <= out_second_distance
      && out_second_distance <= NO_DIST)
    else $error("distances out of order");

  // With a match the best distance is a real one.
  a_found_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_best_distance < NO_DIST)
    else $error("match reported with no distance");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result present straight after reset");

endmodule

bind hamming_best_match_ratio_test hbm_checker u_hbm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_found           (out_found),
  .out_accepted        (out_accepted),
  .out_match_index     (out_match_index),
  .out_best_distance   (out_best_distance),
  .out_second_distance (out_second_distance)
);
